[src/smrf_pkg.sv]
// Shared constants and types for the sonar median-of-five range filter.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package smrf_pkg;

  // Widths of the stream and register fields.
  localparam int unsigned ChannelWidth = 2;
  localparam int unsigned EchoWidth    = 16;
  localparam int unsigned ScaleWidth   = 16;
  localparam int unsigned OffsetWidth  = 8;
  localparam int unsigned MmWidth      = 14;
  localparam int unsigned DistWidth    = 15;
  localparam int unsigned ProdWidth    = EchoWidth + ScaleWidth;

  // History layout: one memory row per channel, entry 0 (newest) in the low bits.
  localparam int unsigned HistoryDepth = 4;
  localparam int unsigned RowWidth     = HistoryDepth * DistWidth;
  localparam int unsigned MedianCount  = HistoryDepth + 1;

  localparam int unsigned ChannelCountDef = 3;

  typedef logic signed [DistWidth-1:0] dist_t;
  typedef logic [RowWidth-1:0]         row_t;

  localparam logic [MmWidth-1:0] DistMax       = 14'd16383;
  localparam dist_t              ResetDistance = 15'sd200;
  localparam row_t               ResetRow      = {HistoryDepth{ResetDistance}};

  // Register map: register index in paddr[3:2].
  localparam int unsigned RegIdxWidth = 2;
  localparam int unsigned AddrWidth   = RegIdxWidth + 2;
  localparam logic [RegIdxWidth-1:0] RegEchoScale    = 2'd0;
  localparam logic [RegIdxWidth-1:0] RegSensorOffset = 2'd1;
  localparam logic [RegIdxWidth-1:0] RegNoEchoDist   = 2'd2;

  localparam logic [ScaleWidth-1:0]  EchoScaleReset   = 16'd11299;
  localparam logic [OffsetWidth-1:0] SensorOffsetReset = 8'd0;
  localparam logic [MmWidth-1:0]     NoEchoDistReset   = 14'd200;

endpackage

[src/sonar_median5_range_filter.sv]
// Sonar median-of-five range filter, top level.
// Results pass the stage 1, stage 2 and output registers; stage 2 holds on a stall.
// New items are taken while one earlier item is in flight; the history memory row is
// read on input, written back the next cycle; a forwarding register covers the overlap.
// Reset: asynchronous, active low; registers return to their defaults and every
// channel's history reads as 200 mm through per-row valid bits, with no clearing pass.
`timescale 1ns / 1ps

module sonar_median5_range_filter #(
  parameter int unsigned ChannelCount = smrf_pkg::ChannelCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] echo_time_us
  input  logic [1:0]  s_axis_tuser,   // [1:0] channel
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [14:0] filtered_distance_mm, [15] zero
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [smrf_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  import smrf_pkg::*;

  localparam int unsigned ChAddrW = (ChannelCount > 1) ? $clog2(ChannelCount) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ScaleWidth-1:0]  echo_scale_q;
  logic [OffsetWidth-1:0] sensor_offset_q;
  logic [MmWidth-1:0]     no_echo_dist_q;
  logic                   cfg_write;
  logic [RegIdxWidth-1:0] reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[AddrWidth-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_scale_q    <= EchoScaleReset;
      sensor_offset_q <= SensorOffsetReset;
      no_echo_dist_q  <= NoEchoDistReset;
    end else if (cfg_write) begin
      case (reg_idx)
        RegEchoScale:    echo_scale_q    <= pwdata[ScaleWidth-1:0];
        RegSensorOffset: sensor_offset_q <= pwdata[OffsetWidth-1:0];
        RegNoEchoDist:   no_echo_dist_q  <= pwdata[MmWidth-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      RegEchoScale:    prdata = 32'(echo_scale_q);
      RegSensorOffset: prdata = 32'(sensor_offset_q);
      RegNoEchoDist:   prdata = 32'(no_echo_dist_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control: the read stage never stalls, so an item is taken only when
  // the two downstream slots can absorb everything in flight.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic in_fire, out_fire, out_adv;
  logic [1:0] occupancy;

  assign out_fire  = out_valid_q && m_axis_tready;
  assign out_adv   = !out_valid_q || m_axis_tready;
  assign occupancy = 2'(s1_valid_q) + 2'(s2_valid_q) + 2'(out_valid_q) - 2'(out_fire);
  assign s_axis_tready = (occupancy <= 2'd1);
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Stage 1 capture: memory read issue and the Q0.16 multiply.
  // ---------------------------------------------------------------------------
  logic                 s1_bad_q;
  logic [ChAddrW-1:0]   s1_addr_q;
  logic [ProdWidth-1:0] s1_prod_q;
  logic [ChAddrW-1:0]   in_addr;
  logic                 in_bad;

  assign in_addr = ChAddrW'(s_axis_tuser);
  assign in_bad  = (32'(s_axis_tuser) >= 32'(ChannelCount));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_bad_q  <= in_bad;
      s1_addr_q <= in_addr;
      s1_prod_q <= s_axis_tdata[EchoWidth-1:0] * echo_scale_q;
    end
  end

  // ---------------------------------------------------------------------------
  // History memory, one row of four distances per channel.
  // ---------------------------------------------------------------------------
  logic               wr_en;
  row_t               ram_rdata;
  row_t               new_row;

  smrf_ram #(
    .Width (RowWidth),
    .Depth (ChannelCount)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (new_row),
    .re_i    (in_fire),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // Row valid bits stand in for the reset contents of the memory.
  logic [ChannelCount-1:0] row_valid_q;
  // Last written row, forwarded when the next item reads the same channel.
  logic                    lw_valid_q;
  logic [ChAddrW-1:0]      lw_addr_q;
  row_t                    lw_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      lw_valid_q  <= 1'b0;
    end else begin
      lw_valid_q <= wr_en;
      if (wr_en) begin
        row_valid_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lw_addr_q <= s1_addr_q;
      lw_row_q  <= new_row;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: corrected distance, history row selection and write-back.
  // ---------------------------------------------------------------------------
  logic [MmWidth-1:0] mm_sat;
  dist_t              fresh;
  row_t               hist_row;

  always_comb begin
    // Saturate the truncated product at the top of the 14-bit range.
    if (s1_prod_q[ProdWidth-1:16+MmWidth] != '0) begin
      mm_sat = DistMax;
    end else begin
      mm_sat = s1_prod_q[16+MmWidth-1:16];
    end
    if (mm_sat == '0) begin
      fresh = dist_t'({1'b0, no_echo_dist_q});
    end else begin
      fresh = dist_t'({1'b0, mm_sat}) - dist_t'({7'd0, sensor_offset_q});
    end

    if (lw_valid_q && (lw_addr_q == s1_addr_q)) begin
      hist_row = lw_row_q;
    end else if (row_valid_q[s1_addr_q]) begin
      hist_row = ram_rdata;
    end else begin
      hist_row = ResetRow;
    end
  end

  assign wr_en   = s1_valid_q && !s1_bad_q;
  assign new_row = {hist_row[RowWidth-DistWidth-1:0], fresh};

  // ---------------------------------------------------------------------------
  // Stage 2: the five candidates; an unknown channel loads zeros so its median is zero.
  // ---------------------------------------------------------------------------
  dist_t s2_vals_q [MedianCount];
  logic  s2_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q || (s2_valid_q && !out_adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_bad_q <= s1_bad_q;
      for (int k = 0; k < HistoryDepth; k++) begin
        s2_vals_q[k] <= s1_bad_q ? '0 : dist_t'(hist_row[k*DistWidth +: DistWidth]);
      end
      s2_vals_q[HistoryDepth] <= s1_bad_q ? '0 : fresh;
    end
  end

  // Median by rank: an element with at most two smaller and at least two
  // other not-larger values is the third smallest.
  dist_t      median;
  logic [2:0] n_less [MedianCount];
  logic [2:0] n_leq  [MedianCount];

  always_comb begin
    median = s2_vals_q[0];
    for (int i = 0; i < MedianCount; i++) begin
      n_less[i] = '0;
      n_leq[i]  = '0;
      for (int j = 0; j < MedianCount; j++) begin
        if (j != i) begin
          n_less[i] = n_less[i] + 3'(s2_vals_q[j] < s2_vals_q[i]);
          n_leq[i]  = n_leq[i] + 3'(s2_vals_q[j] <= s2_vals_q[i]);
        end
      end
    end
    for (int i = MedianCount - 1; i >= 0; i--) begin
      if ((n_less[i] <= 3'd2) && (n_leq[i] >= 3'd2)) begin
        median = s2_vals_q[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  dist_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s2_valid_q) begin
      out_data_q <= median;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_data_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // An item leaving the read stage always finds room in stage 2.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (!s2_valid_q || out_adv))
    else $error("stage 2 overrun by read stage");

  // Stage 1 items are never dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> s2_valid_q)
    else $error("item lost after read stage");

  // An unknown channel yields a zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && out_adv && s2_bad_q) |=> (out_valid_q && (out_data_q == '0)))
    else $error("unknown channel did not give zero");
`endif

endmodule

[src/smrf_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependencies.
`timescale 1ns / 1ps

module smrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; a read of the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[verif/sonar_median5_range_filter_tb.sv]
// Self-checking testbench for the sonar median-of-five range filter.
// Holds its own model of the echo conversion and per-channel median history.
// Uses smrf_pkg and the sonar_median5_range_filter top level only.
`timescale 1ns / 1ps

module sonar_median5_range_filter_tb;
  import smrf_pkg::*;

  localparam int unsigned Channels      = ChannelCountDef;
  localparam int unsigned PhaseCount    = 6;
  localparam int unsigned PhaseItems    = 220;
  localparam int unsigned BurstItems    = 100;
  localparam int unsigned BackupItems   = 60;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned WatchdogLimit = 2000;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata  = '0;  // [15:0] echo_time_us
  logic [1:0]           s_axis_tuser  = '0;  // [1:0] channel
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;        // [14:0] filtered_distance_mm, [15] zero
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [AddrWidth-1:0] paddr         = '0;
  logic [31:0]          pwdata        = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // Model state: configuration and per-channel history, entry 0 newest.
  logic [ScaleWidth-1:0]  model_scale;
  logic [OffsetWidth-1:0] model_offset;
  logic [MmWidth-1:0]     model_no_echo;
  dist_t                  echo_history [Channels][HistoryDepth];

  dist_t       pending_distances [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  bit          no_gaps        = 1'b0;
  bit          hold_request   = 1'b0;
  int unsigned echo_target [Channels];

  sonar_median5_range_filter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Converts one echo to a corrected distance, takes the median of five and
  // shifts the corrected distance into the channel's history.
  function automatic dist_t filter_echo(logic [ChannelWidth-1:0] ch, logic [EchoWidth-1:0] echo);
    logic [ProdWidth-1:0] product;
    int                   mm;
    int                   fresh;
    int                   window [MedianCount];
    int                   swap;
    if (ch >= Channels) return '0;
    product = ProdWidth'(echo) * ProdWidth'(model_scale);
    mm = int'(product[ProdWidth-1:16]);
    if (mm > int'(DistMax)) mm = int'(DistMax);
    if (mm == 0) fresh = int'(model_no_echo);
    else fresh = mm - int'(model_offset);
    for (int k = 0; k < HistoryDepth; k++) window[k] = int'(echo_history[ch][k]);
    window[HistoryDepth] = fresh;
    for (int i = 0; i < MedianCount - 1; i++) begin
      for (int j = 0; j < MedianCount - 1 - i; j++) begin
        if (window[j] > window[j+1]) begin
          swap = window[j];
          window[j] = window[j+1];
          window[j+1] = swap;
        end
      end
    end
    for (int k = HistoryDepth - 1; k > 0; k--) echo_history[ch][k] = echo_history[ch][k-1];
    echo_history[ch][0] = dist_t'(fresh);
    return dist_t'(window[MedianCount / 2]);
  endfunction

  // Offers one echo after a random gap and records the predicted distance
  // at the transfer edge. Returns at that edge with tvalid still high.
  task automatic send_echo(input logic [ChannelWidth-1:0] ch, input logic [EchoWidth-1:0] echo);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= echo;
    s_axis_tuser  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_distances.push_back(filter_echo(ch, echo));
  endtask

  // Random echo: partly a jittered target per channel so the median sees
  // steady readings with outliers, plus no-echo, tiny, huge and fully random times.
  task automatic send_random_echo();
    logic [ChannelWidth-1:0] ch;
    int                      echo;
    ch = ($urandom_range(0, 15) == 0) ? ChannelWidth'(3) : ChannelWidth'($urandom_range(0, 2));
    case ($urandom_range(0, 9))
      0: echo = 0;
      1: echo = $urandom_range(1, 16);
      2: echo = $urandom_range(16'hFF00, 16'hFFFF);
      3, 4, 5: begin
        echo = (ch < Channels) ? int'(echo_target[ch]) : 0;
        echo = echo + $urandom_range(0, 8) - 4;
        if (echo < 0) echo = 0;
        if (echo > 65535) echo = 65535;
      end
      default: echo = $urandom_range(0, 65535);
    endcase
    send_echo(ch, EchoWidth'(echo));
  endtask

  // Stops offering items and waits until every predicted result has arrived.
  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes one register while the block is idle: setup cycle, then access.
  task automatic write_reg(input logic [RegIdxWidth-1:0] idx, input logic [31:0] value);
    drain_stream();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegEchoScale:    model_scale   = value[ScaleWidth-1:0];
      RegSensorOffset: model_offset  = value[OffsetWidth-1:0];
      RegNoEchoDist:   model_no_echo = value[MmWidth-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input int unsigned scale, input int unsigned offset,
                              input int unsigned no_echo);
    write_reg(RegEchoScale, scale);
    write_reg(RegSensorOffset, offset);
    write_reg(RegNoEchoDist, no_echo);
  endtask

  task automatic reset_block();
    model_scale   = EchoScaleReset;
    model_offset  = SensorOffsetReset;
    model_no_echo = NoEchoDistReset;
    for (int c = 0; c < Channels; c++)
      for (int k = 0; k < HistoryDepth; k++) echo_history[c][k] = ResetDistance;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  // Reset values: no echo, zero after truncation, out-of-range channel,
  // ties in the window and a single spike that the median must reject.
  task automatic test_reset_defaults();
    send_echo(2'd0, 16'd0);
    send_echo(2'd1, 16'd1);
    send_echo(2'd2, 16'd6);
    send_echo(2'd0, 16'hFFFF);
    send_echo(2'd3, 16'hFFFF);
    send_echo(2'd3, 16'd0);
    send_echo(2'd1, 16'd1000);
    send_echo(2'd1, 16'd1000);
    send_echo(2'd1, 16'd1000);
    send_echo(2'd0, 16'd5000);
    send_echo(2'd0, 16'd5000);
    send_echo(2'd0, 16'd60000);
    send_echo(2'd0, 16'd5000);
  endtask

  // Register extremes: saturation, negative corrected distances, zero scale.
  task automatic test_config_extremes();
    apply_config(32'hFFFF, 32'd255, 32'd16383);
    send_echo(2'd0, 16'hFFFF);
    send_echo(2'd0, 16'd16384);
    send_echo(2'd1, 16'd1);
    send_echo(2'd2, 16'd2);
    send_echo(2'd2, 16'd0);
    send_echo(2'd2, 16'd3);
    send_echo(2'd3, 16'd5);
    apply_config(32'd0, 32'd0, 32'd0);
    send_echo(2'd0, 16'hFFFF);
    send_echo(2'd1, 16'd0);
    send_echo(2'd2, 16'h8000);
  endtask

  // Random traffic under a new register setting per phase.
  task automatic test_random_traffic();
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: apply_config(32'hFFFF, 32'd255, 32'd16383);
        1: apply_config(32'd1, 32'd0, 32'd0);
        2: apply_config(EchoScaleReset, $urandom_range(0, 255), $urandom_range(0, 16383));
        default: apply_config($urandom_range(0, 65535), $urandom_range(0, 255),
                              $urandom_range(0, 16383));
      endcase
      for (int c = 0; c < Channels; c++) echo_target[c] = $urandom_range(0, 65535);
      repeat (PhaseItems) send_random_echo();
    end
  endtask

  // Back-to-back items on both sides.
  task automatic test_no_idle();
    no_gaps = 1'b1;
    repeat (BurstItems) send_random_echo();
    no_gaps = 1'b0;
    drain_stream();
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // block fills up and has to stall its input.
  task automatic test_backpressure();
    no_gaps      = 1'b1;
    hold_request = 1'b1;
    repeat (BackupItems) send_random_echo();
    no_gaps = 1'b0;
    drain_stream();
  endtask

  // Result side: random stall before each transfer, or a long hold on request.
  initial begin
    int unsigned stall;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      if (hold_request) begin
        stall        = HoldCycles;
        hold_request = 1'b0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compares every result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    dist_t predicted;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_distances.size() == 0) begin
        $error("filtered_distance_mm: expected none, actual %0d", $signed(m_axis_tdata[14:0]));
        mismatch_count++;
      end else begin
        predicted = pending_distances.pop_front();
        if (m_axis_tdata[14:0] !== predicted) begin
          $error("filtered_distance_mm: expected %0d, actual %0d",
                 predicted, $signed(m_axis_tdata[14:0]));
          mismatch_count++;
        end
        if (m_axis_tdata[15] !== 1'b0) begin
          $error("tdata pad bit: expected 0, actual %b", m_axis_tdata[15]);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run when nothing has moved on any port for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("sonar_median5_range_filter_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    reset_block();
    test_reset_defaults();
    test_config_extremes();
    test_random_traffic();
    test_no_idle();
    test_backpressure();
    drain_stream();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_distances.size() == 0) begin
      $display("sonar_median5_range_filter_tb: clean");
    end else begin
      $display("sonar_median5_range_filter_tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
src/smrf_pkg.sv
src/smrf_ram.sv
src/sonar_median5_range_filter.sv
verif/sonar_median5_range_filter_tb.sv
